// ----- rtl/core/kpsne_pkg.sv -----
// kpsne_pkg: shared types, codes and the key table for the keypad scanner core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kpsne_pkg;

	// scan sequencer phases; unused codes fall back to idle
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_SCAN     = 3'd1,
		PH_COLREAD  = 3'd2,
		PH_RELEASE  = 3'd3,
		PH_DEBOUNCE = 3'd4
	} phase_t;

	// result kinds carried on the master tuser
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_APPEND = 2'd1,
		EV_DELETE = 2'd2,
		EV_FINISH = 2'd3
	} key_event_t;

	localparam int unsigned COL_W      = 4;
	localparam int unsigned ROW_W      = 4;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned DEBOUNCE_W = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd100;
	localparam logic [COL_W-1:0]      COLS_RELEASED  = 4'hF;
	localparam logic [ROW_W-1:0]      ROWS_ALL_LOW   = 4'h0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'h3D;

	// reciprocal of ten, scaled by 2^35; exact for any 32-bit dividend
	localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;

	// row pattern: all rows high but the scanned one
	function automatic logic [ROW_W-1:0] row_pattern(input logic [1:0] row);
		logic [ROW_W-1:0] pat;
		pat      = '1;
		pat[row] = 1'b0;
		return pat;
	endfunction

	// key layout: "123A" "456B" "789C" "*0=D"
	function automatic logic [CHAR_W-1:0] key_lookup(input logic [1:0] row,
		input logic [1:0] col);
		logic [CHAR_W-1:0] ch;
		unique case ({row, col})
			4'h0: ch = 8'h31;
			4'h1: ch = 8'h32;
			4'h2: ch = 8'h33;
			4'h3: ch = 8'h41;
			4'h4: ch = 8'h34;
			4'h5: ch = 8'h35;
			4'h6: ch = 8'h36;
			4'h7: ch = 8'h42;
			4'h8: ch = 8'h37;
			4'h9: ch = 8'h38;
			4'hA: ch = 8'h39;
			4'hB: ch = 8'h43;
			4'hC: ch = CHAR_STAR;
			4'hD: ch = CHAR_ZERO;
			4'hE: ch = CHAR_EQUAL;
			default: ch = 8'h44;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/core/kpsne_div10.sv -----
// kpsne_div10: registered divide-by-ten of the entry value.
// Depends on kpsne_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps

module kpsne_div10 (
	input  logic                          clk,
	input  logic [kpsne_pkg::VALUE_W-1:0] value,
	output logic [kpsne_pkg::VALUE_W-1:0] quot_q
);
	import kpsne_pkg::*;

	logic [2*VALUE_W-1:0] product;

	// multiply by the scaled reciprocal, keep the top bits
	assign product = {{VALUE_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP_TEN};

	always_ff @(posedge clk) begin
		quot_q <= {{RECIP_SHIFT - VALUE_W{1'b0}}, product[2*VALUE_W-1:RECIP_SHIFT]};
	end

endmodule

// ----- rtl/core/keypad_scan_number_entry_core.sv -----
// keypad_scan_number_entry_core: 4x4 keypad scan sequencer with decimal entry.
// Depends on kpsne_pkg and kpsne_div10.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | word contents (low bit up)
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata[3:0] col_sample, [7:4] zero
//  m_      | out | m_tvalid/m_tready  | tdata[3:0] row_drive, [11:4] key_char,
//          |     |                    |   [43:12] entry_value, [47:44] zero;
//          |     |                    | tuser[1:0] key_event
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data[15:0] debounce_ticks
//
// One input word yields one result word. Each accepted word is processed in the
// cycle it arrives and its result lands in the output register on that edge, so a
// word can be taken every cycle; s_tready drops only while a result is held by a
// stalled m_tready. The divide-by-ten for delete comes from a registered reciprocal
// multiply of the entry value, which is always settled by the time a key applies.
// arst_n clears the sequencer, entry value and output valid; debounce resets to 100.
// Configuration is always ready; write it only while the block is idle (unchecked).

module keypad_scan_number_entry_core (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: col_sample[3:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// tdata: row_drive[3:0], key_char[11:4], entry_value[43:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	// tuser: key_event[1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [kpsne_pkg::DEBOUNCE_W-1:0] cfg_data
);
	import kpsne_pkg::*;

	// sequencer state
	phase_t                phase_q, phase_d;
	logic [1:0]            scan_row_q, scan_row_d;
	logic [CHAR_W-1:0]     pending_q, pending_d;
	logic [DEBOUNCE_W-1:0] delay_q, delay_d;
	logic [VALUE_W-1:0]    acc_q, acc_d;
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [VALUE_W-1:0]    acc_div10_q;

	// result register
	logic                  out_valid_q;
	logic [ROW_W-1:0]      row_q, row_d;
	key_event_t            ev_q, ev_d;
	logic [CHAR_W-1:0]     char_q, char_d;
	logic [VALUE_W-1:0]    shown_q, shown_d;

	logic [COL_W-1:0]      cols;
	logic                  step;
	logic                  col_hit;
	logic [1:0]            col_idx;
	logic [VALUE_W-1:0]    acc_times10;
	logic [VALUE_W-1:0]    digit;

	assign cols      = s_tdata[COL_W-1:0];
	assign s_tready  = !out_valid_q || m_tready;
	assign step      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, shown_q, char_q, row_q};
	assign m_tuser  = ev_q;

	kpsne_div10 u_div10 (
		.clk    (clk),
		.value  (acc_q),
		.quot_q (acc_div10_q)
	);

	// lowest-numbered pressed column
	always_comb begin
		col_hit = 1'b1;
		col_idx = 2'd0;
		if (!cols[0])      col_idx = 2'd0;
		else if (!cols[1]) col_idx = 2'd1;
		else if (!cols[2]) col_idx = 2'd2;
		else if (!cols[3]) col_idx = 2'd3;
		else               col_hit = 1'b0;
	end

	assign acc_times10 = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0};
	assign digit       = {{VALUE_W-CHAR_W{1'b0}}, pending_q - CHAR_ZERO};

	// next state and result for one tick
	always_comb begin
		phase_d    = PH_IDLE;
		scan_row_d = scan_row_q;
		pending_d  = pending_q;
		delay_d    = delay_q;
		acc_d      = acc_q;
		row_d      = ROWS_ALL_LOW;
		ev_d       = EV_NONE;
		char_d     = '0;
		unique case (phase_q)
			PH_SCAN: begin
				if (cols != COLS_RELEASED) begin
					phase_d = PH_COLREAD;
				end else if (scan_row_q == 2'd3) begin
					phase_d    = PH_IDLE;
					scan_row_d = 2'd0;
				end else begin
					phase_d    = PH_SCAN;
					scan_row_d = scan_row_q + 2'd1;
					row_d      = row_pattern(scan_row_q + 2'd1);
				end
			end
			PH_COLREAD: begin
				// press gone before the column read: back to idle, no key
				if (col_hit) begin
					pending_d = key_lookup(scan_row_q, col_idx);
					phase_d   = PH_RELEASE;
				end
				scan_row_d = 2'd0;
			end
			PH_RELEASE: begin
				phase_d = PH_RELEASE;
				if (cols == COLS_RELEASED) begin
					delay_d = debounce_q;
					phase_d = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (delay_q != '0) begin
					delay_d = delay_q - DEBOUNCE_W'(1);
					phase_d = PH_DEBOUNCE;
				end else if (pending_q >= CHAR_ZERO && pending_q <= CHAR_NINE) begin
					acc_d  = acc_times10 + digit;
					ev_d   = EV_APPEND;
					char_d = pending_q;
				end else if (pending_q == CHAR_STAR) begin
					// delete on zero value does nothing
					if (acc_q != '0) begin
						acc_d  = acc_div10_q;
						ev_d   = EV_DELETE;
						char_d = pending_q;
					end
				end else if (pending_q == CHAR_EQUAL) begin
					ev_d   = EV_FINISH;
					char_d = pending_q;
				end
			end
			default: begin
				if (cols != COLS_RELEASED) begin
					phase_d    = PH_SCAN;
					scan_row_d = 2'd0;
					row_d      = row_pattern(2'd0);
				end
			end
		endcase
		shown_d = acc_d;
		if (ev_d == EV_FINISH) begin
			acc_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			scan_row_q <= 2'd0;
			pending_q  <= '0;
			delay_q    <= '0;
			acc_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			scan_row_q <= scan_row_d;
			pending_q  <= pending_d;
			delay_q    <= delay_d;
			acc_q      <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			row_q   <= row_d;
			ev_q    <= ev_d;
			char_q  <= char_d;
			shown_q <= shown_d;
		end
	end

	// a key only applies with all rows released to low drive
	a_event_rows_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != EV_NONE) |-> (m_tdata[3:0] == ROWS_ALL_LOW))
		else $error("key event with a row being scanned");

	// a finished entry leaves the accumulator cleared
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ev_d == EV_FINISH) |=> (acc_q == '0))
		else $error("entry value not cleared after finish");

	// no key char without an event
	a_char_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == EV_NONE) |-> (m_tdata[11:4] == '0))
		else $error("key char reported without an event");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output register");

	// a key only reaches debounce from the release wait or by counting down
	a_debounce_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q != PH_DEBOUNCE && phase_d == PH_DEBOUNCE)
			|-> (phase_q == PH_RELEASE))
		else $error("debounce entered from a wrong phase");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// testbench: checks keypad_scan_number_entry_core word by word against an
// in-bench model of the scan sequencer and decimal entry. Depends on kpsne_pkg.

module testbench;
	import kpsne_pkg::*;

	// one expected result word
	typedef struct packed {
		logic [ROW_W-1:0]   rows;
		key_event_t         ev;
		logic [CHAR_W-1:0]  ch;
		logic [VALUE_W-1:0] value;
	} scan_result_t;

	// key layout, byte index {row, col}: "123A" "456B" "789C" "*0=D"
	localparam logic [127:0] KEYPAD_CHARS = {"D=0*", "C987", "B654", "A321"};
	localparam int HOLDOFF_CYCLES = 400;
	localparam int PHASE_WORDS    = 280;
	localparam int MAX_REPORTS    = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [DEBOUNCE_W-1:0] cfg_data = '0;

	keypad_scan_number_entry_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// model state, starts at reset values
	phase_t             scan_phase = PH_IDLE;
	logic [1:0]         probe_row = '0;
	logic [CHAR_W-1:0]  held_key = '0;
	logic [15:0]        settle_left = '0;
	logic [VALUE_W-1:0] entry_acc = '0;
	logic [15:0]        cfg_debounce = DEBOUNCE_RESET;

	logic [3:0]   col_q[$];      // column words waiting to be sent
	scan_result_t expected_q[$]; // results still owed by the block
	int  words_queued = 0;
	int  words_taken = 0;
	int  fail_count = 0;
	bit  word_taken = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	bit  holdoff_req = 1'b0;
	int  holdoff_left = 0;
	int  ready_mode = 0;
	int  mode_left = 0;

	// one tick of the scanner: advance the model and owe one result word
	task automatic predict_scan(input logic [3:0] cols);
		scan_result_t r;
		r.rows  = ROWS_ALL_LOW;
		r.ev    = EV_NONE;
		r.ch    = '0;
		r.value = '0;
		case (scan_phase)
			PH_SCAN: begin
				if (cols != COLS_RELEASED) begin
					scan_phase = PH_COLREAD;
				end else if (probe_row == 2'd3) begin
					// press vanished during the row scan
					scan_phase = PH_IDLE;
					probe_row  = '0;
				end else begin
					probe_row = probe_row + 2'd1;
					r.rows    = ~(4'b0001 << probe_row);
				end
			end
			PH_COLREAD: begin
				// lowest low column wins; none low means back to idle
				scan_phase = PH_IDLE;
				for (int c = 3; c >= 0; c--) begin
					if (!cols[c]) begin
						held_key   = KEYPAD_CHARS[{probe_row, c[1:0]} * 8 +: 8];
						scan_phase = PH_RELEASE;
					end
				end
				probe_row = '0;
			end
			PH_RELEASE: begin
				if (cols == COLS_RELEASED) begin
					settle_left = cfg_debounce;
					scan_phase  = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (settle_left != 0) begin
					settle_left = settle_left - 16'd1;
				end else begin
					scan_phase = PH_IDLE;
					if (held_key >= CHAR_ZERO && held_key <= CHAR_NINE) begin
						entry_acc = entry_acc * 32'd10 + 32'(held_key - CHAR_ZERO);
						r.ev = EV_APPEND;
						r.ch = held_key;
					end else if (held_key == CHAR_STAR) begin
						// delete on zero does nothing
						if (entry_acc != 0) begin
							entry_acc = entry_acc / 32'd10;
							r.ev = EV_DELETE;
							r.ch = held_key;
						end
					end else if (held_key == CHAR_EQUAL) begin
						r.ev = EV_FINISH;
						r.ch = held_key;
					end
				end
			end
			default: begin
				scan_phase = PH_IDLE;
				if (cols != COLS_RELEASED) begin
					scan_phase = PH_SCAN;
					probe_row  = '0;
					r.rows     = 4'b1110;
				end
			end
		endcase
		r.value = entry_acc;
		if (r.ev == EV_FINISH)
			entry_acc = '0;
		expected_q.push_back(r);
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
		end
	endtask

	// monitor: results first, then the input word taken on this edge
	always @(posedge clk) begin : monitor
		scan_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected result word, expected none actual %h/%h",
							$time, m_tuser, m_tdata);
				end else begin
					want = expected_q.pop_front();
					flag_mismatch("row_drive", 32'(want.rows), 32'(m_tdata[3:0]));
					flag_mismatch("key_event", 32'(want.ev), 32'(m_tuser));
					flag_mismatch("key_char", 32'(want.ch), 32'(m_tdata[11:4]));
					flag_mismatch("entry_value", want.value, m_tdata[43:12]);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_scan(s_tdata[3:0]);
				word_taken = 1'b1;
				words_taken++;
			end
		end
	end

	// sender: bursts of random length, random gaps, some stretches gap-free
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (col_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {4'h0, col_q.pop_front()};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: always ready, mostly ready or mostly stalled, plus a long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (holdoff_req) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_req  = 1'b0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left  = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (ready_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic queue_cols(input logic [3:0] cols);
		col_q.push_back(cols);
		words_queued++;
	endtask

	function automatic logic [3:0] any_pressed();
		return 4'($urandom_range(0, 14));
	endfunction

	// column word whose lowest low bit is col
	function automatic logic [3:0] column_hit(input int col);
		logic [3:0] v;
		v = 4'($urandom);
		v[col] = 1'b0;
		for (int i = 0; i < col; i++)
			v[i] = 1'b1;
		return v;
	endfunction

	// full press: detect, scan down to row, read column, hold, release, settle
	task automatic queue_key(input int row, input int col, input int hold);
		queue_cols(any_pressed());
		repeat (row) queue_cols(COLS_RELEASED);
		queue_cols(any_pressed());
		queue_cols(column_hit(col));
		repeat (hold) queue_cols(any_pressed());
		queue_cols(COLS_RELEASED);
		repeat (int'(cfg_debounce) + 1) queue_cols(4'($urandom));
	endtask

	// press that is gone before any row answers
	task automatic queue_lost_row();
		queue_cols(any_pressed());
		repeat (4) queue_cols(COLS_RELEASED);
	endtask

	// row found, but all columns high at the column read
	task automatic queue_lost_col(input int row);
		queue_cols(any_pressed());
		repeat (row) queue_cols(COLS_RELEASED);
		queue_cols(any_pressed());
		queue_cols(COLS_RELEASED);
	endtask

	// random garbage, then enough released words to land back in idle
	task automatic queue_noise(input int n);
		repeat (n) queue_cols(4'($urandom));
		repeat (int'(cfg_debounce) + 6) queue_cols(COLS_RELEASED);
	endtask

	// sender stays quiet until every owed result has come back
	task automatic wait_drained();
		while (words_taken != words_queued || expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [15:0] ticks);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_debounce = ticks;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int pick;
		int start_words;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset debounce: '1' with every column low throughout
		queue_cols(4'h0);
		queue_cols(4'h0);
		queue_cols(4'h0);
		queue_cols(COLS_RELEASED);
		repeat (int'(cfg_debounce) + 1) queue_cols(4'($urandom));
		wait_drained();

		// no settle delay: each operation and corner once
		write_debounce(16'd0);
		queue_key(3, 0, 1);           // delete, value 1 -> 0
		queue_key(3, 0, 0);           // delete on zero
		queue_key(3, 3, 0);           // letter keys are ignored
		queue_key(0, 3, 2);
		queue_key(1, 3, 0);
		queue_key(2, 3, 1);
		queue_lost_row();
		queue_lost_col(2);
		repeat (11) queue_key(2, 2, 0); // nines until the value wraps
		queue_key(3, 2, 0);           // finish
		queue_key(3, 1, 3);           // zero digit
		queue_key(3, 2, 0);           // finish on zero
		queue_key(1, 0, 0);
		queue_key(2, 1, 0);
		wait_drained();

		// long settle delay, one key
		write_debounce(16'd200);
		queue_key(1, 1, 2);
		wait_drained();

		// random phases, mostly clean presses with random content
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_debounce(16'd1);
				1: write_debounce(16'd2);
				2: write_debounce(16'd5);
				default: write_debounce(16'($urandom_range(0, 15)));
			endcase
			start_words = words_queued;
			while (words_queued - start_words < PHASE_WORDS) begin
				repeat ($urandom_range(0, 2)) queue_cols(COLS_RELEASED);
				pick = $urandom_range(0, 99);
				if (pick < 80)
					queue_key($urandom_range(0, 3), $urandom_range(0, 3),
						$urandom_range(0, 3));
				else if (pick < 87)
					queue_noise($urandom_range(1, 8));
				else if (pick < 94)
					queue_lost_row();
				else
					queue_lost_col($urandom_range(0, 3));
			end
			// receiver holds off while the sender keeps offering words
			if (p == 1)
				holdoff_req = 1'b1;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/kpsne_pkg.sv
rtl/core/kpsne_div10.sv
rtl/core/keypad_scan_number_entry_core.sv
test/testbench.sv
